// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/hrhp_pkg.sv -----
// ---------------------------------------------------------------------------
// HTTP/1 request head parser package
// Phase encoding, byte classes, status codes, method table and lookup.
// ---------------------------------------------------------------------------
package hrhp_pkg;

   typedef enum logic [14:0] {
      PH_RL_START = 15'b000000000000001,
      PH_METHOD   = 15'b000000000000010,
      PH_SP1      = 15'b000000000000100,
      PH_PATH     = 15'b000000000001000,
      PH_QUERY    = 15'b000000000010000,
      PH_FRAG     = 15'b000000000100000,
      PH_SP2      = 15'b000000001000000,
      PH_VERSION  = 15'b000000010000000,
      PH_VTAIL    = 15'b000000100000000,
      PH_HSTART   = 15'b000001000000000,
      PH_HNAME    = 15'b000010000000000,
      PH_HSEP     = 15'b000100000000000,
      PH_HVALUE   = 15'b001000000000000,
      PH_HBAD     = 15'b010000000000000,
      PH_DONE     = 15'b100000000000000
   } phase_type;

   localparam logic [3:0] CLS_SKIP    = 4'd0;
   localparam logic [3:0] CLS_METHOD  = 4'd1;
   localparam logic [3:0] CLS_PATH    = 4'd2;
   localparam logic [3:0] CLS_QUERY   = 4'd3;
   localparam logic [3:0] CLS_FRAG    = 4'd4;
   localparam logic [3:0] CLS_VERSION = 4'd5;
   localparam logic [3:0] CLS_HNAME   = 4'd6;
   localparam logic [3:0] CLS_HVALUE  = 4'd7;
   localparam logic [3:0] CLS_LINE    = 4'd8;

   localparam logic [2:0] ST_RUNNING    = 3'd0;
   localparam logic [2:0] ST_HEAD_DONE  = 3'd1;
   localparam logic [2:0] ST_BAD_SPACE  = 3'd2;
   localparam logic [2:0] ST_NO_METHOD  = 3'd3;
   localparam logic [2:0] ST_UNKNOWN    = 3'd4;
   localparam logic [2:0] ST_NO_URL     = 3'd5;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd6;
   localparam logic [2:0] ST_CLOSED     = 3'd7;

   localparam logic [3:0] METHOD_NONE = 4'd0;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_HASH  = 8'h23;

   localparam logic [15:0] MAX_HEAD_RESET = 16'd8192;
   localparam logic [3:0]  METHOD_MAX_LEN = 4'd8;
   localparam int          METHOD_COUNT   = 9;

   localparam logic [55:0] METHOD_NAME [METHOD_COUNT] = '{
      56'h00000000474554,
      56'h000000504F5354,
      56'h00000000505554,
      56'h0044454C455445,
      56'h00000048454144,
      56'h4F5054494F4E53,
      56'h00005452414345,
      56'h00005041544348,
      56'h434F4E4E454354
   };

   localparam logic [3:0] METHOD_LEN [METHOD_COUNT] = '{
      4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd5, 4'd7
   };

   function automatic logic [3:0] method_lookup(input logic [55:0] chars,
                                                input logic [3:0]  len);
      logic [3:0] code;
      code = METHOD_NONE;
      for (int i = METHOD_COUNT - 1; i >= 0; i--) begin
         if (len == METHOD_LEN[i] && chars == METHOD_NAME[i]) begin
            code = 4'(i + 1);
         end
      end
      return code;
   endfunction

endpackage

// ----- hw/rtl/http1_request_head_parser.sv -----
// ---------------------------------------------------------------------------
// HTTP/1 request head parser
// Classifies the bytes of a request head one at a time, with a one-byte
// look-ahead for CR-LF and colon-space, and reports method and errors.
// ---------------------------------------------------------------------------
// The req channel carries one received byte per item, with flags for a new
// connection and for a closed connection. The rsp channel carries at most one
// item per input item: the previous byte tagged by class, a line end, or a
// status item. Because each byte is held back until the next one arrives, a
// byte's result appears when the following item is accepted.
// The parse state and the held byte are updated at the accepting edge and the
// result is registered and visible on rsp_ in the cycle after. One item can be
// accepted in every cycle while req_stall is low; the combinational next-state
// logic of the parse state machine sets this rate.
// The csr channel writes the head size limit; it is always ready and should
// only be written while the block is idle.
// Reset clears the parse state, drops any pending result and loads the
// default limit of 8192 bytes. While a result waits and rsp_stall is high,
// req_stall is raised; otherwise items are accepted even with a result
// pending, since that result leaves in the same cycle.
// ---------------------------------------------------------------------------
module http1_request_head_parser #(
   parameter int HEAD_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_new_connection,
   input  logic        req_conn_closed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_out,
   output logic [3:0]  rsp_byte_class,
   output logic [3:0]  rsp_method_code,
   output logic        rsp_header_ok,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_head_bytes
);

   localparam int CMP_W = (HEAD_COUNT_BITS > 16) ? HEAD_COUNT_BITS : 16;

   hrhp_pkg::phase_type          phase_ff, phase_in;
   logic [7:0]                   held_ff, held_in;
   logic                         held_valid_ff, held_valid_in;
   logic [55:0]                  mchars_ff, mchars_in;
   logic [3:0]                   mlen_ff, mlen_in;
   logic [HEAD_COUNT_BITS-1:0]   count_ff, count_in;
   logic [2:0]                   flags_ff, flags_in;
   logic                         error_ff, error_in;
   logic [15:0]                  max_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [7:0]                   rsp_byte_ff, rsp_byte_in;
   logic [3:0]                   rsp_class_ff, rsp_class_in;
   logic [3:0]                   rsp_code_ff, rsp_code_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [2:0]                   rsp_status_ff, rsp_status_in;

   logic                         accept;
   logic                         produce;
   logic                         do_url;
   logic                         colon_space;
   logic [7:0]                   cur_byte;
   logic [3:0]                   lookup_code;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      mchars_in     = mchars_ff;
      mlen_in       = mlen_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      error_in      = error_ff;
      produce       = 1'b0;
      do_url        = 1'b0;
      cur_byte      = held_ff;
      colon_space   = 1'b0;
      lookup_code   = hrhp_pkg::METHOD_NONE;
      rsp_byte_in   = '0;
      rsp_class_in  = hrhp_pkg::CLS_SKIP;
      rsp_code_in   = hrhp_pkg::METHOD_NONE;
      rsp_ok_in     = 1'b0;
      rsp_status_in = hrhp_pkg::ST_RUNNING;

      if (req_new_connection) begin
         phase_in      = hrhp_pkg::PH_RL_START;
         held_in       = '0;
         held_valid_in = 1'b0;
         mchars_in     = '0;
         mlen_in       = '0;
         count_in      = '0;
         flags_in      = '0;
         error_in      = 1'b0;
      end

      if (!error_in && phase_in != hrhp_pkg::PH_DONE) begin
         if (req_conn_closed) begin
            error_in      = 1'b1;
            held_valid_in = 1'b0;
            produce       = 1'b1;
            rsp_status_in = hrhp_pkg::ST_CLOSED;
         end else if (CMP_W'(count_in) >= CMP_W'(max_ff)) begin
            error_in      = 1'b1;
            held_valid_in = 1'b0;
            produce       = 1'b1;
            rsp_status_in = hrhp_pkg::ST_TOO_LARGE;
         end else begin
            if (count_in != '1) begin
               count_in = count_in + 1'b1;
            end
            if (!held_valid_in) begin
               held_in       = req_data_byte;
               held_valid_in = 1'b1;
            end else if (held_in == hrhp_pkg::CHAR_CR &&
                         req_data_byte == hrhp_pkg::CHAR_LF) begin
               held_valid_in = 1'b0;
               produce       = 1'b1;
               case (phase_in)
                  hrhp_pkg::PH_RL_START, hrhp_pkg::PH_SP1, hrhp_pkg::PH_SP2: begin
                     error_in      = 1'b1;
                     rsp_status_in = hrhp_pkg::ST_BAD_SPACE;
                  end
                  hrhp_pkg::PH_METHOD: begin
                     error_in      = 1'b1;
                     rsp_status_in = hrhp_pkg::ST_NO_METHOD;
                  end
                  hrhp_pkg::PH_PATH, hrhp_pkg::PH_QUERY, hrhp_pkg::PH_FRAG: begin
                     error_in      = 1'b1;
                     rsp_status_in = hrhp_pkg::ST_NO_URL;
                  end
                  hrhp_pkg::PH_VERSION, hrhp_pkg::PH_VTAIL: begin
                     phase_in     = hrhp_pkg::PH_HSTART;
                     flags_in     = '0;
                     rsp_class_in = hrhp_pkg::CLS_LINE;
                  end
                  default: begin
                     rsp_class_in = hrhp_pkg::CLS_LINE;
                     if (!flags_in[0]) begin
                        phase_in      = hrhp_pkg::PH_DONE;
                        rsp_status_in = hrhp_pkg::ST_HEAD_DONE;
                     end else begin
                        rsp_ok_in = (phase_in == hrhp_pkg::PH_HVALUE);
                        phase_in  = hrhp_pkg::PH_HSTART;
                        flags_in  = '0;
                     end
                  end
               endcase
            end else begin
               cur_byte     = held_in;
               held_in      = req_data_byte;
               colon_space  = (cur_byte == hrhp_pkg::CHAR_COLON) &&
                              (req_data_byte == hrhp_pkg::CHAR_SP);
               flags_in[0]  = 1'b1;
               produce      = 1'b1;
               rsp_byte_in  = cur_byte;
               case (phase_in)
                  hrhp_pkg::PH_RL_START, hrhp_pkg::PH_METHOD: begin
                     if (cur_byte == hrhp_pkg::CHAR_SP) begin
                        if (phase_in == hrhp_pkg::PH_METHOD) begin
                           lookup_code = hrhp_pkg::method_lookup(mchars_in, mlen_in);
                           if (lookup_code == hrhp_pkg::METHOD_NONE) begin
                              error_in      = 1'b1;
                              held_valid_in = 1'b0;
                              rsp_byte_in   = '0;
                              rsp_status_in = hrhp_pkg::ST_UNKNOWN;
                           end else begin
                              phase_in    = hrhp_pkg::PH_SP1;
                              rsp_code_in = lookup_code;
                           end
                        end
                     end else begin
                        phase_in = hrhp_pkg::PH_METHOD;
                        if (mlen_in < hrhp_pkg::METHOD_MAX_LEN) begin
                           mchars_in = {mchars_in[47:0], cur_byte};
                           mlen_in   = mlen_in + 1'b1;
                        end
                        rsp_class_in = hrhp_pkg::CLS_METHOD;
                     end
                  end
                  hrhp_pkg::PH_SP1: begin
                     if (cur_byte != hrhp_pkg::CHAR_SP) begin
                        phase_in = hrhp_pkg::PH_PATH;
                        do_url   = 1'b1;
                     end
                  end
                  hrhp_pkg::PH_PATH, hrhp_pkg::PH_QUERY, hrhp_pkg::PH_FRAG: begin
                     do_url = 1'b1;
                  end
                  hrhp_pkg::PH_SP2: begin
                     if (cur_byte != hrhp_pkg::CHAR_SP) begin
                        phase_in     = hrhp_pkg::PH_VERSION;
                        rsp_class_in = hrhp_pkg::CLS_VERSION;
                     end
                  end
                  hrhp_pkg::PH_VERSION: begin
                     if (cur_byte == hrhp_pkg::CHAR_SP) begin
                        phase_in = hrhp_pkg::PH_VTAIL;
                     end else begin
                        rsp_class_in = hrhp_pkg::CLS_VERSION;
                     end
                  end
                  hrhp_pkg::PH_HSTART: begin
                     if (cur_byte != hrhp_pkg::CHAR_SP) begin
                        if (colon_space) begin
                           phase_in = hrhp_pkg::PH_HBAD;
                        end else begin
                           phase_in     = hrhp_pkg::PH_HNAME;
                           flags_in[1]  = 1'b1;
                           rsp_class_in = hrhp_pkg::CLS_HNAME;
                        end
                     end
                  end
                  hrhp_pkg::PH_HNAME: begin
                     if (colon_space) begin
                        phase_in = hrhp_pkg::PH_HSEP;
                     end else begin
                        rsp_class_in = hrhp_pkg::CLS_HNAME;
                     end
                  end
                  hrhp_pkg::PH_HSEP: begin
                     if (cur_byte != hrhp_pkg::CHAR_SP) begin
                        phase_in     = hrhp_pkg::PH_HVALUE;
                        flags_in[2]  = 1'b1;
                        rsp_class_in = hrhp_pkg::CLS_HVALUE;
                     end
                  end
                  hrhp_pkg::PH_HVALUE: begin
                     rsp_class_in = hrhp_pkg::CLS_HVALUE;
                  end
                  default: begin
                  end
               endcase

               if (do_url) begin
                  if (cur_byte == hrhp_pkg::CHAR_SP) begin
                     phase_in = hrhp_pkg::PH_SP2;
                  end else if (phase_in != hrhp_pkg::PH_FRAG &&
                               cur_byte == hrhp_pkg::CHAR_HASH) begin
                     phase_in = hrhp_pkg::PH_FRAG;
                  end else if (phase_in == hrhp_pkg::PH_PATH &&
                               cur_byte == hrhp_pkg::CHAR_QMARK) begin
                     phase_in = hrhp_pkg::PH_QUERY;
                  end else if (phase_in == hrhp_pkg::PH_PATH) begin
                     rsp_class_in = hrhp_pkg::CLS_PATH;
                  end else if (phase_in == hrhp_pkg::PH_QUERY) begin
                     rsp_class_in = hrhp_pkg::CLS_QUERY;
                  end else begin
                     rsp_class_in = hrhp_pkg::CLS_FRAG;
                  end
               end
            end
         end
      end

      if (accept) begin
         rsp_valid_in = produce;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= hrhp_pkg::PH_RL_START;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         mchars_ff     <= '0;
         mlen_ff       <= '0;
         count_ff      <= '0;
         flags_ff      <= '0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
            mchars_ff     <= mchars_in;
            mlen_ff       <= mlen_in;
            count_ff      <= count_in;
            flags_ff      <= flags_in;
            error_ff      <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= hrhp_pkg::MAX_HEAD_RESET;
      end else if (csr_valid && csr_ready) begin
         max_ff <= csr_max_head_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_class_ff  <= rsp_class_in;
         rsp_code_ff   <= rsp_code_in;
         rsp_ok_ff     <= rsp_ok_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_out    = rsp_byte_ff;
   assign rsp_byte_class  = rsp_class_ff;
   assign rsp_method_code = rsp_code_ff;
   assign rsp_header_ok   = rsp_ok_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ----- hw/rtl/hrhp_checker.sv -----
// ---------------------------------------------------------------------------
// HTTP/1 request head parser checker
// Port-level assertions on the result channel and the input stall, bound to the parser module.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hrhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_byte_out,
   input logic [3:0]  rsp_byte_class,
   input logic [3:0]  rsp_method_code,
   input logic        rsp_header_ok,
   input logic [2:0]  rsp_status
);

   logic [19:0] rsp_item;
   logic        rsp_held;
   logic        rsp_error;
   logic        rsp_blank;
   logic        rsp_coded;
   logic        rsp_on_space;
   logic        rsp_ok_seen;
   logic        rsp_line;

   assign rsp_item     = {rsp_byte_out, rsp_byte_class, rsp_method_code, rsp_header_ok,
                          rsp_status};
   assign rsp_held     = rsp_valid && rsp_stall;
   assign rsp_error    = rsp_valid && (rsp_status >= hrhp_pkg::ST_BAD_SPACE);
   assign rsp_blank    = (rsp_byte_out == 8'h00) && (rsp_byte_class == hrhp_pkg::CLS_SKIP) &&
                         (rsp_method_code == hrhp_pkg::METHOD_NONE) && !rsp_header_ok;
   assign rsp_coded    = rsp_valid && (rsp_method_code != hrhp_pkg::METHOD_NONE);
   assign rsp_on_space = (rsp_byte_out == hrhp_pkg::CHAR_SP) &&
                         (rsp_byte_class == hrhp_pkg::CLS_SKIP);
   assign rsp_ok_seen  = rsp_valid && rsp_header_ok;
   assign rsp_line     = (rsp_byte_class == hrhp_pkg::CLS_LINE);

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid && $stable(rsp_item), "item changed")

   `CHK_ASSERT(a_req_backpressure, clock, reset, rsp_held |-> req_stall, "input taken in stall")

   `CHK_ASSERT(a_error_item_clean, clock, reset, rsp_error |-> rsp_blank, "error item has data")

   `CHK_ASSERT(a_method_on_space, clock, reset, rsp_coded |-> rsp_on_space, "method code misplaced")

   `CHK_ASSERT(a_ok_on_line_end, clock, reset, rsp_ok_seen |-> rsp_line, "header_ok off line end")

endmodule

bind http1_request_head_parser hrhp_checker u_hrhp_checker (.*);
